/* rtl/accel_vibration_moving_average_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the vibration moving-average unit
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ACCEL_VIBRATION_MOVING_AVERAGE_UNIT_MACROS_SVH
`define ACCEL_VIBRATION_MOVING_AVERAGE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AVMU_ASSERT_IMPL(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("avmu: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define AVMU_ASSERT_NEXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("avmu: next-cycle check failed");

`endif

/* rtl/avmu_pkg.sv */
// ----------------------------------------------------------------------------
// avmu_pkg
// Widths, window length and register indexes for the vibration unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package avmu_pkg;

  localparam int WINDOW = 10;

  localparam int AXIS_W = 16;
  localparam int OFFS_W = 13;
  localparam int ONEG_W = 16;
  localparam int CORR_W = 17;
  localparam int MAG_W  = 16;
  localparam int SOS_W  = 32;
  localparam int ROOT_W = SOS_W / 2;
  localparam int VIB_W  = 17;
  localparam int SUM_W  = VIB_W + $clog2(WINDOW);
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_G    = 2'd3;

  typedef logic signed [VIB_W-1:0] vib_t;

endpackage

/* rtl/accel_vibration_moving_average_unit.sv */
// One accelerometer sample (three signed axes) goes in per transfer and one
// result comes out: the offset-corrected vector magnitude less the one-g
// count, and the truncated mean of the last ten such values (entries not yet
// written count as zero). Work is serial throughout: the sum of squares is
// formed one multiplier bit at a time, the square root one root bit at a
// time, and the window sum is divided by the window length one quotient bit
// at a time; a new sample is not taken until the previous one is finished
// and its result handed to the output register. A new sample is taken while
// the previous result still waits on a stalled output.
// Configuration writes take effect at once and belong in idle periods.
`timescale 1ns / 1ps

`include "accel_vibration_moving_average_unit_macros.svh"

module accel_vibration_moving_average_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [avmu_pkg::AXIS_W-1:0]    in_accel_x,
  input  logic signed [avmu_pkg::AXIS_W-1:0]    in_accel_y,
  input  logic signed [avmu_pkg::AXIS_W-1:0]    in_accel_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output avmu_pkg::vib_t                        out_vibration_now,
  output avmu_pkg::vib_t                        out_vibration_smoothed,
  input  logic                                  cfg_we,
  input  logic [avmu_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [avmu_pkg::CFG_DAT_W-1:0]        cfg_wdata
);
  import avmu_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_ROOT   = 3'd2;
  localparam logic [2:0] ST_MEAN   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  localparam int MCNT_W = $clog2(MAG_W);

  logic [2:0]               state_r, state_nxt;
  logic [OFFS_W-1:0]        offset_x_r, offset_y_r, offset_z_r;
  logic [ONEG_W-1:0]        one_g_r;
  logic [MAG_W-1:0]         mag_x_r, mag_y_r, mag_z_r;
  logic [MAG_W-1:0]         sh_x_r, sh_y_r, sh_z_r;
  logic [MAG_W-1:0]         sh_x_nxt, sh_y_nxt, sh_z_nxt;
  logic [SOS_W-1:0]         acc_r, acc_nxt;
  logic [MCNT_W-1:0]        mcnt_r, mcnt_nxt;
  logic                     root_start_r, root_start_nxt;
  logic                     mean_start_r, mean_start_nxt;
  vib_t                     vib_r, vib_nxt;
  vib_t                     now_r, smooth_r;
  logic                     out_valid_r, out_valid_nxt;
  logic                     load_out;
  logic                     in_fire;
  logic                     root_done, mean_done;
  logic [ROOT_W-1:0]        root;
  vib_t                     mean;
  logic [MAG_W-1:0]         mag_x, mag_y, mag_z;
  logic [MAG_W-1:0]         pp_x, pp_y, pp_z;

  // Magnitude of an offset-corrected axis; it never exceeds 36864.
  function automatic logic [MAG_W-1:0] corr_mag(logic [AXIS_W-1:0] a,
                                                 logic [OFFS_W-1:0] o);
    logic [CORR_W-1:0] c;
    logic [CORR_W-1:0] m;
    c = {a[AXIS_W-1], a} + {{(CORR_W - OFFS_W){o[OFFS_W-1]}}, o};
    m = c[CORR_W-1] ? (~c + 1'b1) : c;
    return m[MAG_W-1:0];
  endfunction

  assign mag_x = corr_mag(in_accel_x, offset_x_r);
  assign mag_y = corr_mag(in_accel_y, offset_y_r);
  assign mag_z = corr_mag(in_accel_z, offset_z_r);

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign load_out = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

  // All three squares share the multiplier bit position, so one accumulator
  // doubles each cycle and takes the three partial products together.
  assign pp_x = sh_x_r[MAG_W-1] ? mag_x_r : '0;
  assign pp_y = sh_y_r[MAG_W-1] ? mag_y_r : '0;
  assign pp_z = sh_z_r[MAG_W-1] ? mag_z_r : '0;

  always_comb begin
    state_nxt      = state_r;
    sh_x_nxt       = sh_x_r;
    sh_y_nxt       = sh_y_r;
    sh_z_nxt       = sh_z_r;
    acc_nxt        = acc_r;
    mcnt_nxt       = mcnt_r;
    root_start_nxt = 1'b0;
    mean_start_nxt = 1'b0;
    vib_nxt        = vib_r;
    out_valid_nxt  = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          sh_x_nxt  = mag_x;
          sh_y_nxt  = mag_y;
          sh_z_nxt  = mag_z;
          acc_nxt   = '0;
          mcnt_nxt  = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        acc_nxt = {acc_r[SOS_W-2:0], 1'b0}
                + {{(SOS_W - MAG_W){1'b0}}, pp_x}
                + {{(SOS_W - MAG_W){1'b0}}, pp_y}
                + {{(SOS_W - MAG_W){1'b0}}, pp_z};
        sh_x_nxt = {sh_x_r[MAG_W-2:0], 1'b0};
        sh_y_nxt = {sh_y_r[MAG_W-2:0], 1'b0};
        sh_z_nxt = {sh_z_r[MAG_W-2:0], 1'b0};
        mcnt_nxt = mcnt_r + 1'b1;
        if (mcnt_r == MCNT_W'(MAG_W - 1)) begin
          root_start_nxt = 1'b1;
          state_nxt      = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          vib_nxt        = vib_t'({1'b0, root} - {1'b0, one_g_r});
          mean_start_nxt = 1'b1;
          state_nxt      = ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (mean_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      root_start_r <= 1'b0;
      mean_start_r <= 1'b0;
      mcnt_r       <= '0;
      offset_x_r   <= OFFS_W'(240);
      offset_y_r   <= OFFS_W'(-150);
      offset_z_r   <= OFFS_W'(1876);
      one_g_r      <= ONEG_W'(16384);
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      root_start_r <= root_start_nxt;
      mean_start_r <= mean_start_nxt;
      mcnt_r       <= mcnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_OFFSET_X: offset_x_r <= cfg_wdata[OFFS_W-1:0];
          REG_OFFSET_Y: offset_y_r <= cfg_wdata[OFFS_W-1:0];
          REG_OFFSET_Z: offset_z_r <= cfg_wdata[OFFS_W-1:0];
          REG_ONE_G:    one_g_r    <= cfg_wdata[ONEG_W-1:0];
          default: begin
          end
        endcase
      end
    end
    sh_x_r <= sh_x_nxt;
    sh_y_r <= sh_y_nxt;
    sh_z_r <= sh_z_nxt;
    acc_r  <= acc_nxt;
    vib_r  <= vib_nxt;
    if (in_fire) begin
      mag_x_r <= mag_x;
      mag_y_r <= mag_y;
      mag_z_r <= mag_z;
    end
    if (load_out) begin
      now_r    <= vib_r;
      smooth_r <= mean;
    end
  end

  avmu_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start_r),
    .radicand (acc_r),
    .done     (root_done),
    .root     (root)
  );

  avmu_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mean_start_r),
    .vib   (vib_r),
    .done  (mean_done),
    .mean  (mean)
  );

  assign out_valid              = out_valid_r;
  assign out_vibration_now      = now_r;
  assign out_vibration_smoothed = smooth_r;

  `AVMU_ASSERT_NEXT(a_accept_starts_mul, clk, rst_n, in_fire, state_r == ST_MUL)
  `AVMU_ASSERT_IMPL(a_root_done_in_phase, clk, rst_n, root_done, state_r == ST_ROOT)
  `AVMU_ASSERT_IMPL(a_mean_done_in_phase, clk, rst_n, mean_done, state_r == ST_MEAN)
  `AVMU_ASSERT_IMPL(a_result_from_finish, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_FINISH)

endmodule

/* rtl/avmu_isqrt.sv */
// ----------------------------------------------------------------------------
// avmu_isqrt
// Bit-serial floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module avmu_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [avmu_pkg::SOS_W-1:0]  radicand,
  output logic                        done,
  output logic [avmu_pkg::ROOT_W-1:0] root
);
  import avmu_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W);

  logic [SOS_W-1:0]  rad_r, rad_nxt;
  logic [ROOT_W:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;

  // Two radicand bits enter the partial remainder on every step.
  assign rem_sh = {rem_r, rad_r[SOS_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[SOS_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh[ROOT_W:0] - trial[ROOT_W:0];
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[ROOT_W:0];
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ROOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

/* rtl/avmu_window.sv */
// ----------------------------------------------------------------------------
// avmu_window
// Ring window with running sum and a bit-serial divide by the window length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module avmu_window (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  avmu_pkg::vib_t vib,
  output logic           done,
  output avmu_pkg::vib_t mean
);
  import avmu_pkg::*;

  localparam int REM_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(SUM_W);
  localparam logic [REM_W:0] WIN_C = (REM_W + 1)'(WINDOW);

  vib_t                    store_r [WINDOW];
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W-1:0]        dvd_r, dvd_nxt;
  logic [SUM_W-1:0]        quo_r, quo_nxt;
  logic [REM_W-1:0]        rem_r, rem_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    neg_r, neg_nxt;
  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [REM_W:0]          rem_sh;
  logic signed [SUM_W-1:0] old_ext;
  logic signed [SUM_W-1:0] vib_ext;
  logic [VIB_W-1:0]        quo_lo;

  assign old_ext = {{(SUM_W - VIB_W){store_r[slot_r][VIB_W-1]}}, store_r[slot_r]};
  assign vib_ext = {{(SUM_W - VIB_W){vib[VIB_W-1]}}, vib};
  assign rem_sh  = {rem_r, dvd_r[SUM_W-1]};

  always_comb begin
    slot_nxt = slot_r;
    sum_nxt  = sum_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      sum_nxt  = sum_r - old_ext + vib_ext;
      slot_nxt = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
      // The divide works on the magnitude; the sign is put back at the end.
      neg_nxt  = sum_nxt[SUM_W-1];
      dvd_nxt  = sum_nxt[SUM_W-1] ? (~sum_nxt + 1'b1) : sum_nxt;
      quo_nxt  = '0;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[SUM_W-2:0], 1'b0};
      if (rem_sh >= WIN_C) begin
        rem_nxt = REM_W'(rem_sh - WIN_C);
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[REM_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      sum_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      slot_r <= slot_nxt;
      sum_r  <= sum_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      if (start) begin
        store_r[slot_r] <= vib;
      end
    end
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  assign quo_lo = quo_r[VIB_W-1:0];
  assign done   = done_r;
  assign mean   = neg_r ? vib_t'(~quo_lo + 1'b1) : vib_t'(quo_lo);

endmodule

/* tb/sv/accel_vibration_moving_average_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_vibration_moving_average_unit_tb
// Drives accelerometer samples through the vibration unit under several
// calibration settings with random idle and stall cycles. Every result is
// checked against a local model of the magnitude, the one-g correction and
// the ten-entry moving average.
// ----------------------------------------------------------------------------

module accel_vibration_moving_average_unit_tb;
  import avmu_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 120;

  typedef struct {
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] z;
  } sample_t;

  typedef struct {
    vib_t now_v;
    vib_t mean_v;
  } vib_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [AXIS_W-1:0] in_accel_x = '0;
  logic signed [AXIS_W-1:0] in_accel_y = '0;
  logic signed [AXIS_W-1:0] in_accel_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  vib_t out_vibration_now;
  vib_t out_vibration_smoothed;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  accel_vibration_moving_average_unit uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_accel_x             (in_accel_x),
    .in_accel_y             (in_accel_y),
    .in_accel_z             (in_accel_z),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_vibration_now      (out_vibration_now),
    .out_vibration_smoothed (out_vibration_smoothed),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata)
  );

  // Mirror of the calibration registers and of the averaging window.
  logic signed [OFFS_W-1:0] cal_x = 13'sd240;
  logic signed [OFFS_W-1:0] cal_y = -13'sd150;
  logic signed [OFFS_W-1:0] cal_z = 13'sd1876;
  logic [ONEG_W-1:0] one_g = 16'd16384;
  vib_t win_hist[WINDOW] = '{default: '0};
  int win_slot = 0;
  longint win_total = 0;

  sample_t accel_pending[$];
  vib_result_t vibration_due[$];

  int errors = 0;
  int idle_cycles = 0;
  bit in_took = 1'b0;
  bit out_took = 1'b0;
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;
  int gap_left = 0;
  int hold_left = 0;
  sample_t next_sample;

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic log_mismatch(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Magnitude, gravity removal and window update for one accepted sample.
  task automatic predict_vibration(input logic signed [AXIS_W-1:0] ax,
                                   input logic signed [AXIS_W-1:0] ay,
                                   input logic signed [AXIS_W-1:0] az);
    longint cx, cy, cz, ssq, root, trial, vib, avg;
    vib_result_t r;
    cx = longint'(ax) + longint'(cal_x);
    cy = longint'(ay) + longint'(cal_y);
    cz = longint'(az) + longint'(cal_z);
    ssq = cx * cx + cy * cy + cz * cz;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= ssq) root = trial;
    end
    vib = root - longint'(one_g);
    win_total = win_total - longint'(win_hist[win_slot]) + vib;
    win_hist[win_slot] = vib[VIB_W-1:0];
    win_slot = (win_slot + 1) % WINDOW;
    avg = win_total / WINDOW;
    r.now_v = vib[VIB_W-1:0];
    r.mean_v = avg[VIB_W-1:0];
    vibration_due.push_back(r);
  endtask

  task automatic check_vibration(input vib_t got_now, input vib_t got_mean);
    vib_result_t want;
    if (vibration_due.size() == 0) begin
      log_mismatch($sformatf("result %0d/%0d with nothing expected", got_now, got_mean));
    end else begin
      want = vibration_due.pop_front();
      if (got_now !== want.now_v)
        log_mismatch($sformatf("vibration_now %0d, expected %0d", got_now, want.now_v));
      if (got_mean !== want.mean_v)
        log_mismatch($sformatf("vibration_smoothed %0d, expected %0d", got_mean,
                               want.mean_v));
    end
  endtask

  // Transfers are sampled here, before the block's own updates at this edge.
  always @(posedge clk) begin
    in_took = 1'b0;
    out_took = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        predict_vibration(in_accel_x, in_accel_y, in_accel_z);
      end
      if (out_valid && !out_stall) begin
        out_took = 1'b1;
        check_vibration(out_vibration_now, out_vibration_smoothed);
      end
      if (in_took || out_took) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // Sample driver: the payload only moves after a transfer or while idle.
  always @(negedge clk) begin
    if (in_took || !in_valid) begin
      if (in_took) gap_left = in_idle_on ? $urandom_range(0, 7) : 0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (accel_pending.size() > 0) begin
        next_sample = accel_pending.pop_front();
        in_valid <= 1'b1;
        in_accel_x <= next_sample.x;
        in_accel_y <= next_sample.y;
        in_accel_z <= next_sample.z;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall: drawn per result, held until the result has waited it out.
  always @(negedge clk) begin
    if (out_took) hold_left = out_idle_on ? $urandom_range(0, 7) : 0;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      if (out_valid) hold_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("FAIL accel_vibration_moving_average_unit");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_OFFSET_X: cal_x = val[OFFS_W-1:0];
      REG_OFFSET_Y: cal_y = val[OFFS_W-1:0];
      REG_OFFSET_Z: cal_z = val[OFFS_W-1:0];
      REG_ONE_G:    one_g = val;
      default: ;
    endcase
  endtask

  task automatic queue_sample(input int ax, input int ay, input int az);
    sample_t s;
    s.x = ax[AXIS_W-1:0];
    s.y = ay[AXIS_W-1:0];
    s.z = az[AXIS_W-1:0];
    accel_pending.push_back(s);
  endtask

  task automatic drain();
    while (!(accel_pending.size() == 0 && !in_valid && vibration_due.size() == 0))
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly a sensor near rest with gravity along one axis, plus noise,
  // full-scale patterns and samples that cancel the offsets.
  task automatic queue_random_sample();
    int mode, axis, spread;
    int v[3];
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      spread = (mode < 3) ? 64 : 4096;
      axis = $urandom_range(0, 2);
      v[0] = -int'(cal_x) + $urandom_range(0, 2 * spread) - spread;
      v[1] = -int'(cal_y) + $urandom_range(0, 2 * spread) - spread;
      v[2] = -int'(cal_z) + $urandom_range(0, 2 * spread) - spread;
      v[axis] += ($urandom_range(0, 1) ? int'(one_g) : -int'(one_g));
    end else if (mode < 8) begin
      for (int k = 0; k < 3; k++) v[k] = $urandom_range(0, 65535);
    end else if (mode == 8) begin
      for (int k = 0; k < 3; k++)
        case ($urandom_range(0, 4))
          0: v[k] = -32768;
          1: v[k] = 32767;
          2: v[k] = 0;
          3: v[k] = -1;
          default: v[k] = 1;
        endcase
    end else begin
      v[0] = -int'(cal_x) + $urandom_range(0, 2) - 1;
      v[1] = -int'(cal_y) + $urandom_range(0, 2) - 1;
      v[2] = -int'(cal_z) + $urandom_range(0, 2) - 1;
    end
    queue_sample(v[0], v[1], v[2]);
  endtask

  initial begin
    logic [CFG_DAT_W-1:0] g_pick[6];
    g_pick = '{16'd1, 16'd32768, 16'd0, 16'd16384, 16'd65535, 16'd32767};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset calibration: zero vector, exact one g, perfect squares, full scale,
    // then a filling window and a negative mean that truncates toward zero.
    queue_sample(0, 0, 0);
    queue_sample(-240, 150, -1876);
    queue_sample(-240, 150, 14508);
    queue_sample(-240, 150, 14509);
    queue_sample(-237, 154, -1876);
    queue_sample(-238, 152, -1876);
    queue_sample(-32768, -32768, -32768);
    queue_sample(32767, 32767, 32767);
    queue_sample(32767, -32768, 0);
    queue_sample(-32768, 32767, 32767);
    queue_sample(-240, 150, 32767);
    for (int k = 0; k < 10; k++) queue_sample(-240, 150, 14608);
    for (int k = 0; k < 3; k++) queue_sample(-240, 150, -1876);
    drain();

    // Most negative offsets with a zero one-g count.
    write_reg(REG_OFFSET_X, 16'h1000);
    write_reg(REG_OFFSET_Y, 16'hF000);
    write_reg(REG_OFFSET_Z, 16'h1000);
    write_reg(REG_ONE_G, 16'h0000);
    queue_sample(-32768, -32768, -32768);
    queue_sample(4096, 4096, 4096);
    queue_sample(32767, 32767, 32767);
    drain();

    // Most positive offsets, upper bits set, largest one-g count.
    write_reg(REG_OFFSET_X, 16'hEFFF);
    write_reg(REG_OFFSET_Y, 16'h0FFF);
    write_reg(REG_OFFSET_Z, 16'h2FFF);
    write_reg(REG_ONE_G, 16'hFFFF);
    queue_sample(32767, 32767, 32767);
    queue_sample(-4095, -4095, -4095);
    queue_sample(-32768, 32767, -32768);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      in_idle_on = (p != 2);
      out_idle_on = (p != 2) && (p != 4);
      write_reg(REG_OFFSET_X, CFG_DAT_W'($urandom_range(0, 65535)));
      write_reg(REG_OFFSET_Y, CFG_DAT_W'($urandom_range(0, 65535)));
      write_reg(REG_OFFSET_Z, CFG_DAT_W'($urandom_range(0, 65535)));
      write_reg(REG_ONE_G, (p % 3 == 2) ? CFG_DAT_W'($urandom_range(0, 65535))
                                        : g_pick[p % 6]);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) queue_random_sample();
      drain();
    end

    if (errors == 0) begin
      $display("PASS accel_vibration_moving_average_unit");
    end else begin
      $display("FAIL accel_vibration_moving_average_unit");
    end
    $finish;
  end

endmodule
